// ===== hw/rtl/dtt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline timer table package
// Operation and status codes, sequencer states and the control bundles shared
// by the sequencer and the deadline scan unit.
// ----------------------------------------------------------------------------
package dtt_pkg;

    // Fixed field widths of the request and result ports.
    localparam int OP_W     = 3;
    localparam int IDX_W    = 5;
    localparam int PERIOD_W = 32;
    localparam int NOW_W    = 48;
    localparam int STAT_W   = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_CANCEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_REFRESH = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;
    localparam logic [OP_W-1:0] OP_EXPIRE  = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_ACTIVE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE_DUE   = 3'd4;

    // At most this many slots expire in one request.
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DISP = 7'b0000010,
        S_RD   = 7'b0000100,
        S_CALC = 7'b0001000,
        S_SCAN = 7'b0010000,
        S_QSUB = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // Control into the scan unit.
    typedef struct packed {
        logic clr;       // start a new scan
        logic step;      // one slot's deadline is presented
        logic elig;      // that slot takes part in the scan
        logic due_only;  // only deadlines at or before now count
    } t_scan_ctl;

    // Status out of the scan unit.
    typedef struct packed {
        logic found;     // at least one slot qualified
        logic more;      // two or more slots qualified
    } t_scan_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/dtt_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline timer table arithmetic unit
// Shared adder that saturates at the all-ones time value, or subtractor that
// floors at zero.
// ----------------------------------------------------------------------------
module dtt_alu #(
    parameter int TIME_BITS = 48
) (
    input  wire logic [TIME_BITS-1:0] i_a,
    input  wire logic [TIME_BITS-1:0] i_b,
    input  wire logic                 i_sub,
    output logic      [TIME_BITS-1:0] o_res
);

    logic [TIME_BITS:0] sum;
    logic [TIME_BITS:0] diff;

    // One carry chain each way; the top bit flags overflow or borrow.
    assign sum  = {1'b0, i_a} + {1'b0, i_b};
    assign diff = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        if (i_sub) begin
            o_res = diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
        end else begin
            o_res = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dtt_slot_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline timer table slot memory
// Period and deadline of every slot, one write port and one registered read
// port shared by both arrays. Contents are not cleared by reset.
// ----------------------------------------------------------------------------
module dtt_slot_ram import dtt_pkg::*; #(
    parameter int SLOT_COUNT = 32,
    parameter int TIME_BITS  = 48,
    localparam int SW        = $clog2(SLOT_COUNT)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_dl_we,
    input  wire logic                 i_per_we,
    input  wire logic [SW-1:0]        i_wr_addr,
    input  wire logic [TIME_BITS-1:0] i_wr_deadline,
    input  wire logic [PERIOD_W-1:0]  i_wr_period,
    input  wire logic [SW-1:0]        i_rd_addr,
    output logic      [TIME_BITS-1:0] o_rd_deadline,
    output logic      [PERIOD_W-1:0]  o_rd_period
);

    logic [TIME_BITS-1:0] r_dl_mem  [SLOT_COUNT];
    logic [PERIOD_W-1:0]  r_per_mem [SLOT_COUNT];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_dl_we) begin
            r_dl_mem[i_wr_addr] <= i_wr_deadline;
        end
        if (i_per_we) begin
            r_per_mem[i_wr_addr] <= i_wr_period;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rd_deadline <= r_dl_mem[i_rd_addr];
        o_rd_period   <= r_per_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dtt_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline timer table scan unit
// Takes one slot deadline per step and keeps the earliest qualifying one.
// Slots arrive in rising index order, so a strict compare keeps the lower
// index on ties.
// ----------------------------------------------------------------------------
module dtt_scan import dtt_pkg::*; #(
    parameter int SLOT_COUNT = 32,
    parameter int TIME_BITS  = 48,
    localparam int SW        = $clog2(SLOT_COUNT)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_scan_ctl            i_ctl,
    input  wire logic [SW-1:0]        i_idx,
    input  wire logic [TIME_BITS-1:0] i_deadline,
    input  wire logic [TIME_BITS-1:0] i_now,
    output t_scan_sts                 o_sts,
    output logic      [SW-1:0]        o_best_idx,
    output logic      [TIME_BITS-1:0] o_best_deadline
);

    logic                 r_found;
    logic                 r_more;
    logic [SW-1:0]        r_best_idx;
    logic [TIME_BITS-1:0] r_best_dl;
    logic                 hit;
    logic                 better;

    // A slot qualifies when eligible and, for expiry, already due.
    assign hit    = i_ctl.step && i_ctl.elig && (!i_ctl.due_only || (i_deadline <= i_now));
    assign better = !r_found || (i_deadline < r_best_dl);

    // Qualifying count, saturated at two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_more  <= 1'b0;
        end else if (i_ctl.clr) begin
            r_found <= 1'b0;
            r_more  <= 1'b0;
        end else if (hit) begin
            r_found <= 1'b1;
            r_more  <= r_more | r_found;
        end
    end

    // Best deadline and its slot.
    always_ff @(posedge i_clk) begin
        if (hit && better) begin
            r_best_dl  <= i_deadline;
            r_best_idx <= i_idx;
        end
    end

    assign o_sts.found     = r_found;
    assign o_sts.more      = r_more;
    assign o_best_idx      = r_best_idx;
    assign o_best_deadline = r_best_dl;

endmodule
`default_nettype wire

// ===== hw/rtl/deadline_timer_table.sv =====
// Request to result: cancel, unknown operations, idle refresh and off-table reset answer at
// dispatch; refresh and reset read the slot, and a reset that changes an active slot then
// computes the new deadline and scans; add computes the deadline and scans; query scans,
// then subtracts unless empty; expiry scans per result, rereading each re-armed recurring slot.
// Throughput: one request at a time, paced by the deadline scan reading one slot per cycle.
// Reset (synchronous, active low) clears state, active, recurring and picked marks, front flag and counters.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline timer table
// Table of timer slots with add, cancel, refresh, reset, query and expire
// requests, sequenced over a shared scan unit and a shared adder.
// ----------------------------------------------------------------------------
module deadline_timer_table import dtt_pkg::*; #(
    parameter int SLOT_COUNT = 32,
    parameter int TIME_BITS  = 48
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Request channel
    input  wire logic                i_req_valid,
    output logic                     o_req_ready,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [IDX_W-1:0]    i_slot_index,
    input  wire logic [PERIOD_W-1:0] i_period_ms,
    input  wire logic                i_recurring,
    input  wire logic                i_restart_now,
    input  wire logic [NOW_W-1:0]    i_now_ms,
    // Result channel
    output logic                     o_rsp_valid,
    input  wire logic                i_rsp_ready,
    output logic      [IDX_W-1:0]    o_result_slot,
    output logic      [STAT_W-1:0]   o_status,
    output logic      [NOW_W-1:0]    o_wait_ms,
    output logic                     o_became_front,
    output logic                     o_last
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int AW = SW + 1;
    localparam logic [AW-1:0] SCAN_END = AW'(SLOT_COUNT);
    localparam logic [6:0] SLOT_LIM = 7'(SLOT_COUNT);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    // Control state
    t_state                r_state, n_state;
    logic [SLOT_COUNT-1:0] r_active, n_active;
    logic [SLOT_COUNT-1:0] r_recur, n_recur;
    logic [SLOT_COUNT-1:0] r_picked, n_picked;
    logic                  r_front, n_front;
    logic [CNT_W-1:0]      r_n, n_n;
    logic [AW-1:0]         r_scan_addr, n_scan_addr;
    logic                  r_cmp_vld, n_cmp_vld;
    logic                  r_free_vld, n_free_vld;

    // Request and working payload
    logic [OP_W-1:0]       r_op, n_op;
    logic [IDX_W-1:0]      r_idx_in, n_idx_in;
    logic [SW-1:0]         r_slot, n_slot;
    logic                  r_idx_ok, n_idx_ok;
    logic [PERIOD_W-1:0]   r_period, n_period;
    logic                  r_rec, n_rec;
    logic                  r_restart_now, n_restart_now;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic [TIME_BITS-1:0]  r_acc, n_acc;
    logic [SW-1:0]         r_cmp_idx, n_cmp_idx;
    logic [SW-1:0]         r_free, n_free;

    // Result register
    logic [IDX_W-1:0]      r_o_slot, n_o_slot;
    logic [STAT_W-1:0]     r_o_status, n_o_status;
    logic [NOW_W-1:0]      r_o_wait, n_o_wait;
    logic                  r_o_front, n_o_front;
    logic                  r_o_last, n_o_last;

    // Memory, scan unit and adder connections
    logic                  dl_we;
    logic                  per_we;
    logic [SW-1:0]         wr_addr;
    logic [TIME_BITS-1:0]  wr_dl;
    logic [SW-1:0]         rd_addr;
    logic [TIME_BITS-1:0]  rd_dl;
    logic [PERIOD_W-1:0]   rd_per;
    t_scan_ctl             scan_ctl;
    t_scan_sts             scan_sts;
    logic [SW-1:0]         best_idx;
    logic [TIME_BITS-1:0]  best_dl;
    logic [TIME_BITS-1:0]  alu_a;
    logic [TIME_BITS-1:0]  alu_b;
    logic                  alu_sub;
    logic [TIME_BITS-1:0]  alu_res;
    logic                  scan_issue;
    logic                  scan_done;
    logic [SW-1:0]         tgt;
    logic                  front_win;
    logic                  req_ok;

    dtt_slot_ram #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_ram (
        .i_clk         (i_clk),
        .i_dl_we       (dl_we),
        .i_per_we      (per_we),
        .i_wr_addr     (wr_addr),
        .i_wr_deadline (wr_dl),
        .i_wr_period   (r_period),
        .i_rd_addr     (rd_addr),
        .o_rd_deadline (rd_dl),
        .o_rd_period   (rd_per)
    );

    dtt_scan #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (scan_ctl),
        .i_idx           (r_cmp_idx),
        .i_deadline      (rd_dl),
        .i_now           (r_now),
        .o_sts           (scan_sts),
        .o_best_idx      (best_idx),
        .o_best_deadline (best_dl)
    );

    dtt_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu_res)
    );

    // Handshake and scan progress
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);
    assign req_ok      = i_req_valid && o_req_ready;
    assign scan_issue  = (r_scan_addr < SCAN_END);
    assign scan_done   = (r_state == S_SCAN) && !scan_issue && !r_cmp_vld;

    // Scan unit control: the compare stage works on the slot whose read address was issued in the cycle before.
    always_comb begin
        scan_ctl.clr      = (r_state == S_SCAN) && (r_scan_addr == '0) && !r_cmp_vld;
        scan_ctl.step     = r_cmp_vld;
        scan_ctl.due_only = (r_op == OP_EXPIRE);
        case (r_op)
            OP_EXPIRE: scan_ctl.elig = r_active[r_cmp_idx] && !r_picked[r_cmp_idx];
            OP_RESET:  scan_ctl.elig = r_active[r_cmp_idx] && (r_cmp_idx != r_slot);
            default:   scan_ctl.elig = r_active[r_cmp_idx];
        endcase
    end

    // Read address: scan sweep, the addressed slot, or the slot just picked.
    always_comb begin
        if ((r_state == S_SCAN) && scan_issue) begin
            rd_addr = r_scan_addr[SW-1:0];
        end else if (r_state == S_DISP) begin
            rd_addr = r_slot;
        end else begin
            rd_addr = best_idx;
        end
    end

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = r_acc;
        alu_b   = TIME_BITS'(r_period);
        alu_sub = 1'b0;
        case (r_state)
            S_RD: begin
                if (r_op == OP_RESET) begin
                    // Old start: deadline minus old period, floored at zero.
                    alu_a   = rd_dl;
                    alu_b   = TIME_BITS'(rd_per);
                    alu_sub = 1'b1;
                end else begin
                    alu_a = r_now;
                    alu_b = TIME_BITS'(rd_per);
                end
            end
            S_QSUB: begin
                alu_a   = best_dl;
                alu_b   = r_now;
                alu_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // New deadline becomes the earliest, ties to the lower slot.
    assign tgt       = (r_op == OP_ADD) ? r_free : r_slot;
    assign front_win = !scan_sts.found || (r_acc < best_dl)
                     || ((r_acc == best_dl) && (tgt < best_idx));

    // Memory writes.
    always_comb begin
        dl_we   = 1'b0;
        per_we  = 1'b0;
        wr_addr = r_slot;
        wr_dl   = r_acc;
        if (r_state == S_RD) begin
            if (r_op == OP_REFRESH) begin
                dl_we = 1'b1;
                wr_dl = alu_res;
            end else if (r_op == OP_EXPIRE) begin
                dl_we   = 1'b1;
                wr_addr = best_idx;
                wr_dl   = alu_res;
            end
        end else if (scan_done) begin
            if ((r_op == OP_ADD) && r_free_vld) begin
                dl_we   = 1'b1;
                per_we  = 1'b1;
                wr_addr = r_free;
            end else if (r_op == OP_RESET) begin
                dl_we  = 1'b1;
                per_we = 1'b1;
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state       = r_state;
        n_active      = r_active;
        n_recur       = r_recur;
        n_picked      = r_picked;
        n_front       = r_front;
        n_n           = r_n;
        n_scan_addr   = r_scan_addr;
        n_cmp_vld     = r_cmp_vld;
        n_free_vld    = r_free_vld;
        n_op          = r_op;
        n_idx_in      = r_idx_in;
        n_slot        = r_slot;
        n_idx_ok      = r_idx_ok;
        n_period      = r_period;
        n_rec         = r_rec;
        n_restart_now = r_restart_now;
        n_now         = r_now;
        n_acc         = r_acc;
        n_cmp_idx     = r_cmp_idx;
        n_free        = r_free;
        n_o_slot      = r_o_slot;
        n_o_status    = r_o_status;
        n_o_wait      = r_o_wait;
        n_o_front     = r_o_front;
        n_o_last      = r_o_last;

        case (r_state)
            S_IDLE: begin
                // Capture the request.
                if (req_ok) begin
                    n_op          = i_operation;
                    n_idx_in      = i_slot_index;
                    n_idx_ok      = ({2'b00, i_slot_index} < SLOT_LIM);
                    n_slot        = ({2'b00, i_slot_index} < SLOT_LIM) ? SW'(i_slot_index) : '0;
                    n_period      = i_period_ms;
                    n_rec         = i_recurring;
                    n_restart_now = i_restart_now;
                    n_now         = TIME_BITS'(i_now_ms);
                    n_state       = S_DISP;
                end
            end

            S_DISP: begin
                n_o_slot   = r_idx_in;
                n_o_status = ST_OK;
                n_o_wait   = '0;
                n_o_front  = 1'b0;
                n_o_last   = 1'b1;
                n_state    = S_OUT;
                case (r_op)
                    OP_ADD: begin
                        n_acc   = r_now;
                        n_state = S_CALC;
                    end
                    OP_CANCEL: begin
                        if (r_idx_ok && r_active[r_slot]) begin
                            n_active[r_slot] = 1'b0;
                        end else begin
                            n_o_status = ST_NOT_ACTIVE;
                        end
                    end
                    OP_REFRESH: begin
                        if (r_idx_ok && r_active[r_slot]) begin
                            n_state = S_RD;
                        end else begin
                            n_o_status = ST_NOT_ACTIVE;
                        end
                    end
                    OP_RESET: begin
                        if (r_idx_ok) begin
                            n_state = S_RD;
                        end else begin
                            n_o_status = ST_NOT_ACTIVE;
                        end
                    end
                    OP_QUERY: begin
                        n_front     = 1'b0;
                        n_scan_addr = '0;
                        n_cmp_vld   = 1'b0;
                        n_free_vld  = 1'b0;
                        n_state     = S_SCAN;
                    end
                    OP_EXPIRE: begin
                        n_picked    = '0;
                        n_n         = '0;
                        n_scan_addr = '0;
                        n_cmp_vld   = 1'b0;
                        n_free_vld  = 1'b0;
                        n_state     = S_SCAN;
                    end
                    default: begin
                    end
                endcase
            end

            S_RD: begin
                // Slot memory data for the addressed or picked slot is here.
                n_state = S_OUT;
                if (r_op == OP_RESET) begin
                    if ((r_period == rd_per) && !r_restart_now) begin
                        n_state = S_OUT;
                    end else if (!r_active[r_slot]) begin
                        n_o_status = ST_NOT_ACTIVE;
                    end else begin
                        n_acc   = r_restart_now ? r_now : alu_res;
                        n_state = S_CALC;
                    end
                end
            end

            S_CALC: begin
                // New deadline from the start time and the new period.
                n_acc       = alu_res;
                n_scan_addr = '0;
                n_cmp_vld   = 1'b0;
                n_free_vld  = 1'b0;
                n_state     = S_SCAN;
            end

            S_SCAN: begin
                if (scan_issue) begin
                    n_scan_addr = r_scan_addr + AW'(1);
                    n_cmp_vld   = 1'b1;
                    n_cmp_idx   = r_scan_addr[SW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                // First free slot in index order.
                if (r_cmp_vld && !r_active[r_cmp_idx] && !r_free_vld) begin
                    n_free_vld = 1'b1;
                    n_free     = r_cmp_idx;
                end
                if (scan_done) begin
                    n_state = S_OUT;
                    case (r_op)
                        OP_ADD: begin
                            if (!r_free_vld) begin
                                n_o_status = ST_FULL;
                                n_o_slot   = '0;
                            end else begin
                                n_active[r_free] = 1'b1;
                                n_recur[r_free]  = r_rec;
                                n_o_slot         = IDX_W'(r_free);
                                if (front_win && !r_front) begin
                                    n_o_front = 1'b1;
                                    n_front   = 1'b1;
                                end
                            end
                        end
                        OP_RESET: begin
                            if (front_win && !r_front) begin
                                n_o_front = 1'b1;
                                n_front   = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            if (!scan_sts.found) begin
                                n_o_status = ST_EMPTY;
                                n_o_slot   = '0;
                                n_o_wait   = NOW_W'(TMAX);
                            end else begin
                                n_state = S_QSUB;
                            end
                        end
                        OP_EXPIRE: begin
                            if (!scan_sts.found) begin
                                n_o_status = ST_NONE_DUE;
                                n_o_slot   = '0;
                                n_o_last   = 1'b1;
                            end else begin
                                n_picked[best_idx] = 1'b1;
                                n_n        = r_n + CNT_W'(1);
                                n_o_status = ST_OK;
                                n_o_slot   = IDX_W'(best_idx);
                                n_o_last   = !scan_sts.more
                                           || ((r_n + CNT_W'(1)) == CNT_W'(MAX_RESULTS));
                                if (r_recur[best_idx]) begin
                                    n_state = S_RD;
                                end else begin
                                    n_active[best_idx] = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_QSUB: begin
                n_o_wait = NOW_W'(alu_res);
                n_o_slot = IDX_W'(best_idx);
                n_state  = S_OUT;
            end

            S_OUT: begin
                // Expiry continues with another scan until its final result.
                if (i_rsp_ready) begin
                    if ((r_op == OP_EXPIRE) && !r_o_last) begin
                        n_scan_addr = '0;
                        n_cmp_vld   = 1'b0;
                        n_free_vld  = 1'b0;
                        n_state     = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_recur     <= '0;
            r_picked    <= '0;
            r_front     <= 1'b0;
            r_n         <= '0;
            r_scan_addr <= '0;
            r_cmp_vld   <= 1'b0;
            r_free_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_recur     <= n_recur;
            r_picked    <= n_picked;
            r_front     <= n_front;
            r_n         <= n_n;
            r_scan_addr <= n_scan_addr;
            r_cmp_vld   <= n_cmp_vld;
            r_free_vld  <= n_free_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_idx_in      <= n_idx_in;
        r_slot        <= n_slot;
        r_idx_ok      <= n_idx_ok;
        r_period      <= n_period;
        r_rec         <= n_rec;
        r_restart_now <= n_restart_now;
        r_now         <= n_now;
        r_acc         <= n_acc;
        r_cmp_idx     <= n_cmp_idx;
        r_free        <= n_free;
        r_o_slot      <= n_o_slot;
        r_o_status    <= n_o_status;
        r_o_wait      <= n_o_wait;
        r_o_front     <= n_o_front;
        r_o_last      <= n_o_last;
    end

    assign o_result_slot  = r_o_slot;
    assign o_status       = r_o_status;
    assign o_wait_ms      = r_o_wait;
    assign o_became_front = r_o_front;
    assign o_last         = r_o_last;

`ifndef SYNTHESIS
    // Only expiry gives more than one result per request.
    a_multi_only_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_last) |-> (r_op == OP_EXPIRE))
        else $error("non-final result outside expiry");

    // The front flag is raised only by add or reset.
    a_front_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_front) |-> ($past(r_op) == OP_ADD || $past(r_op) == OP_RESET))
        else $error("front flag raised by another operation");

    // Expiry never goes past its result limit.
    a_expire_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_RESULTS))
        else $error("expiry result count over limit");

    // A front report always comes with a good status.
    a_front_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_became_front) |-> (o_status == ST_OK))
        else $error("front report with error status");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/timer_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table scoreboard
// Keeps a copy of the timer slots and the front flag, predicts the results of
// each accepted request and compares the results of the block against them.
// ----------------------------------------------------------------------------
package timer_scoreboard_pkg;
    import dtt_pkg::*;

    localparam int SLOTS = 32;

    // One result of the block, as seen on the result ports.
    typedef struct {
        logic [IDX_W-1:0]  slot;
        logic [STAT_W-1:0] status;
        logic [NOW_W-1:0]  wait_ms;
        logic              front;
        logic              last;
    } t_timer_result;

    class timer_scoreboard;
        bit                  active[SLOTS];
        bit                  recur[SLOTS];
        bit                  written[SLOTS];
        logic [PERIOD_W-1:0] period[SLOTS];
        logic [NOW_W-1:0]    deadline[SLOTS];
        bit                  front_pending;
        t_timer_result       pending_results[$];
        int                  errors;

        // Deadline sums clamp at the largest time value.
        function logic [NOW_W-1:0] deadline_after(logic [NOW_W-1:0] start,
                                                  logic [PERIOD_W-1:0] span);
            logic [NOW_W:0] sum;
            sum = {1'b0, start} + {{(NOW_W + 1 - PERIOD_W){1'b0}}, span};
            return sum[NOW_W] ? {NOW_W{1'b1}} : sum[NOW_W-1:0];
        endfunction

        // Earliest active slot; ties go to the lower index. -1 when empty.
        function int earliest_slot();
            int best;
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (active[i] && (best < 0 || deadline[i] < deadline[best])) begin
                    best = i;
                end
            end
            return best;
        endfunction

        // A slot that became the earliest raises the front flag once.
        function bit claim_front(int s);
            if (earliest_slot() == s && !front_pending) begin
                front_pending = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void expect_result(int s, logic [STAT_W-1:0] st, logic [NOW_W-1:0] w,
                                    bit f, bit l);
            t_timer_result r;
            r.slot    = IDX_W'(s);
            r.status  = st;
            r.wait_ms = w;
            r.front   = f;
            r.last    = l;
            pending_results = {pending_results, r};
        endfunction

        // Update the slot copy for one accepted request and queue its results.
        function void apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                    logic [PERIOD_W-1:0] per, bit rec, bit restart_now,
                                    logic [NOW_W-1:0] now);
            int               s;
            int               free_slot;
            int               best;
            int               order[$];
            bit               picked[SLOTS];
            logic [NOW_W-1:0] start;
            s = int'(idx);
            case (op)
                OP_ADD: begin
                    free_slot = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!active[i] && free_slot < 0) free_slot = i;
                    end
                    if (free_slot < 0) begin
                        expect_result(0, ST_FULL, '0, 1'b0, 1'b1);
                    end else begin
                        active[free_slot]   = 1'b1;
                        recur[free_slot]    = rec;
                        written[free_slot]  = 1'b1;
                        period[free_slot]   = per;
                        deadline[free_slot] = deadline_after(now, per);
                        expect_result(free_slot, ST_OK, '0, claim_front(free_slot), 1'b1);
                    end
                end
                OP_CANCEL: begin
                    if (!active[s]) begin
                        expect_result(s, ST_NOT_ACTIVE, '0, 1'b0, 1'b1);
                    end else begin
                        active[s] = 1'b0;
                        expect_result(s, ST_OK, '0, 1'b0, 1'b1);
                    end
                end
                OP_REFRESH: begin
                    if (!active[s]) begin
                        expect_result(s, ST_NOT_ACTIVE, '0, 1'b0, 1'b1);
                    end else begin
                        deadline[s] = deadline_after(now, period[s]);
                        expect_result(s, ST_OK, '0, 1'b0, 1'b1);
                    end
                end
                OP_RESET: begin
                    // Same period counted from the old start changes nothing,
                    // even on an inactive slot.
                    if (per == period[s] && !restart_now) begin
                        expect_result(s, ST_OK, '0, 1'b0, 1'b1);
                    end else if (!active[s]) begin
                        expect_result(s, ST_NOT_ACTIVE, '0, 1'b0, 1'b1);
                    end else begin
                        if (restart_now) begin
                            start = now;
                        end else begin
                            start = (deadline[s] >= period[s]) ? deadline[s] - period[s] : '0;
                        end
                        period[s]   = per;
                        deadline[s] = deadline_after(start, per);
                        expect_result(s, ST_OK, '0, claim_front(s), 1'b1);
                    end
                end
                OP_QUERY: begin
                    front_pending = 1'b0;
                    best = earliest_slot();
                    if (best < 0) begin
                        expect_result(0, ST_EMPTY, '1, 1'b0, 1'b1);
                    end else begin
                        expect_result(best, ST_OK,
                                      (deadline[best] > now) ? deadline[best] - now : '0,
                                      1'b0, 1'b1);
                    end
                end
                OP_EXPIRE: begin
                    // Pick due slots in deadline order, lower index first on ties.
                    while (order.size() < MAX_RESULTS) begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (active[i] && !picked[i] && deadline[i] <= now &&
                                (best < 0 || deadline[i] < deadline[best])) begin
                                best = i;
                            end
                        end
                        if (best < 0) break;
                        picked[best] = 1'b1;
                        order = {order, best};
                    end
                    if (order.size() == 0) begin
                        expect_result(0, ST_NONE_DUE, '0, 1'b0, 1'b1);
                    end
                    foreach (order[k]) begin
                        s = order[k];
                        if (recur[s]) begin
                            deadline[s] = deadline_after(now, period[s]);
                        end else begin
                            active[s] = 1'b0;
                        end
                        expect_result(s, ST_OK, '0, 1'b0, k == order.size() - 1);
                    end
                end
                default: begin
                    expect_result(s, ST_OK, '0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest prediction.
        task check_result(logic [IDX_W-1:0] slot, logic [STAT_W-1:0] status,
                          logic [NOW_W-1:0] wait_ms, logic front, logic last);
            t_timer_result e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result slot %0d status %0d", slot, status));
            end else begin
                e = pending_results.pop_front();
                if (slot !== e.slot || status !== e.status || wait_ms !== e.wait_ms ||
                    front !== e.front || last !== e.last) begin
                    report($sformatf({"got slot %0d status %0d wait %0d front %0b last %0b, ",
                                      "want %0d %0d %0d %0b %0b"},
                                     slot, status, wait_ms, front, last,
                                     e.slot, e.status, e.wait_ms, e.front, e.last));
                end
            end
        endtask
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer table testbench
// Drives directed and random timer requests with random idle cycles on both
// channels and checks every result against a predicted copy of the table.
// ----------------------------------------------------------------------------
module tb_top;
    import dtt_pkg::*;
    import timer_scoreboard_pkg::*;

    localparam int RANDOM_REQUESTS = 280;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 2 * SLOTS + 10;

    // Operation codes with no defined meaning.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_req_valid    = 1'b0;
    logic                o_req_ready;
    logic [OP_W-1:0]     i_operation    = '0;
    logic [IDX_W-1:0]    i_slot_index   = '0;
    logic [PERIOD_W-1:0] i_period_ms    = '0;
    logic                i_recurring    = 1'b0;
    logic                i_restart_now  = 1'b0;
    logic [NOW_W-1:0]    i_now_ms       = '0;
    logic                o_rsp_valid;
    logic                i_rsp_ready    = 1'b0;
    logic [IDX_W-1:0]    o_result_slot;
    logic [STAT_W-1:0]   o_status;
    logic [NOW_W-1:0]    o_wait_ms;
    logic                o_became_front;
    logic                o_last;

    timer_scoreboard     sb = new;
    int                  sent_count  = 0;
    int                  quiet_cycles = 0;
    bit                  calm        = 1'b0;
    logic [NOW_W-1:0]    clock_ms    = 48'd3000;

    deadline_timer_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_operation    (i_operation),
        .i_slot_index   (i_slot_index),
        .i_period_ms    (i_period_ms),
        .i_recurring    (i_recurring),
        .i_restart_now  (i_restart_now),
        .i_now_ms       (i_now_ms),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_result_slot  (o_result_slot),
        .o_status       (o_status),
        .o_wait_ms      (o_wait_ms),
        .o_became_front (o_became_front),
        .o_last         (o_last)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: check accepted results, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            sb.check_result(o_result_slot, o_status, o_wait_ms, o_became_front, o_last);
        end
        i_rsp_ready <= calm || ($urandom_range(99) >= 22);
    end

    // Stop the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request, hold it until accepted and hand it to the scoreboard.
    task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                logic [PERIOD_W-1:0] per, bit rec, bit restart_now,
                                logic [NOW_W-1:0] now);
        while (!calm && $urandom_range(99) < 22) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid   <= 1'b1;
        i_operation   <= op;
        i_slot_index  <= idx;
        i_period_ms   <= per;
        i_recurring   <= rec;
        i_restart_now <= restart_now;
        i_now_ms      <= now;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        sb.apply_request(op, idx, per, rec, restart_now, now);
        sent_count++;
        calm = (sent_count >= 150 && sent_count < 200);
    endtask

    // Some active slot, found from a random starting point; -1 when none.
    function automatic int busy_slot();
        int first;
        int s;
        first = $urandom_range(SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            s = (first + i) % SLOTS;
            if (sb.active[s]) return s;
        end
        return -1;
    endfunction

    // One random request. Part of each hundred only adds, to fill the table, and is followed
    // by an expire far in the future that aims to expire every slot, re-arming the recurring ones.
    task automatic random_request(int n);
        int                  pick;
        int                  slot;
        int                  phase;
        logic [OP_W-1:0]     op;
        logic [IDX_W-1:0]    idx;
        logic [PERIOD_W-1:0] per;
        bit                  rec;
        bit                  restart_now;
        pick = $urandom_range(99);
        if (pick < 3) begin
            clock_ms = NOW_W'({$urandom(), $urandom()});
        end else if (pick < 5) begin
            clock_ms = {NOW_W{1'b1}} - NOW_W'($urandom_range(200));
        end else begin
            clock_ms = clock_ms + NOW_W'($urandom_range(40));
        end
        per         = ($urandom_range(99) < 8) ? $urandom() : $urandom_range(200);
        idx         = IDX_W'($urandom_range(SLOTS - 1));
        rec         = 1'($urandom_range(1));
        restart_now = 1'($urandom_range(1));
        phase       = n % 100;
        if (phase >= 40 && phase < 74) begin
            op = OP_ADD;
        end else if (phase == 74) begin
            op = OP_EXPIRE;
            clock_ms = clock_ms + 48'h1_0000_0000;
        end else begin
            pick = $urandom_range(99);
            if (pick < 25)      op = OP_ADD;
            else if (pick < 35) op = OP_CANCEL;
            else if (pick < 45) op = OP_REFRESH;
            else if (pick < 60) op = OP_RESET;
            else if (pick < 74) op = OP_QUERY;
            else if (pick < 96) op = OP_EXPIRE;
            else if (pick < 98) op = OP_SPARE_A;
            else                op = OP_SPARE_B;
        end
        // Requests that address a slot mostly hit a running timer.
        if (op == OP_CANCEL || op == OP_REFRESH || op == OP_RESET) begin
            slot = busy_slot();
            if (slot >= 0 && $urandom_range(99) < 75) idx = IDX_W'(slot);
        end
        // A reset compares against the stored period, so it only goes to
        // slots that have held a timer before.
        if (op == OP_RESET && !sb.written[idx]) begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot < 0 && sb.written[(idx + i) % SLOTS]) slot = (idx + i) % SLOTS;
            end
            if (slot < 0) op = OP_QUERY;
            else          idx = IDX_W'(slot);
        end
        if (op == OP_RESET && $urandom_range(99) < 30) per = sb.period[idx];
        send_request(op, idx, per, rec, restart_now, clock_ms);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, undefined operations.
        send_request(OP_QUERY,   5'd0,  32'd0, 1'b0, 1'b0, 48'd0);
        send_request(OP_EXPIRE,  5'd0,  32'd0, 1'b0, 1'b0, 48'd0);
        send_request(OP_SPARE_A, 5'd31, 32'd0, 1'b1, 1'b1, 48'd0);
        send_request(OP_SPARE_B, 5'd0,  32'd0, 1'b0, 1'b0, 48'd0);
        // Adds, front reporting and query clearing the front flag.
        send_request(OP_ADD,     5'd0,  32'd100, 1'b0, 1'b0, 48'd1000);
        send_request(OP_ADD,     5'd31, 32'd100, 1'b1, 1'b0, 48'd1000);
        send_request(OP_QUERY,   5'd0,  32'd0,   1'b0, 1'b0, 48'd1050);
        send_request(OP_ADD,     5'd0,  32'd0,   1'b1, 1'b0, 48'd1060);
        // Cancel and refresh on running and idle slots.
        send_request(OP_CANCEL,  5'd2,  32'd0,   1'b0, 1'b0, 48'd1070);
        send_request(OP_CANCEL,  5'd2,  32'd0,   1'b0, 1'b0, 48'd1070);
        send_request(OP_REFRESH, 5'd5,  32'd0,   1'b0, 1'b0, 48'd1080);
        send_request(OP_REFRESH, 5'd1,  32'd0,   1'b0, 1'b0, 48'd1200);
        // Reset: unchanged period, idle slot, from old start, from now.
        send_request(OP_RESET,   5'd1,  32'd100, 1'b0, 1'b0, 48'd1200);
        send_request(OP_RESET,   5'd2,  32'd9,   1'b0, 1'b0, 48'd1200);
        send_request(OP_RESET,   5'd2,  32'd0,   1'b0, 1'b0, 48'd1200);
        send_request(OP_RESET,   5'd1,  32'd40,  1'b0, 1'b0, 48'd1210);
        send_request(OP_RESET,   5'd0,  32'd10,  1'b0, 1'b1, 48'd1090);
        // Saturating deadline at the top of the time range.
        send_request(OP_ADD,     5'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 48'hFFFF_FFFF_FF00);
        send_request(OP_RESET,   5'd2,  32'hFFFF_FFFF, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF);
        send_request(OP_QUERY,   5'd0,  32'd0,   1'b0, 1'b0, 48'hFFFF_FFFF_FFFF);
        // Expire some, then everything, then look at what is left.
        send_request(OP_EXPIRE,  5'd0,  32'd0,   1'b0, 1'b0, 48'd2000);
        send_request(OP_EXPIRE,  5'd0,  32'd0,   1'b0, 1'b0, 48'hFFFF_FFFF_FFFF);
        send_request(OP_QUERY,   5'd0,  32'd0,   1'b0, 1'b0, 48'd0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            random_request(n);
        end
        i_req_valid <= 1'b0;

        // Drain the results, then watch for stray ones.
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_alu.sv
hw/rtl/dtt_slot_ram.sv
hw/rtl/dtt_scan.sv
hw/rtl/deadline_timer_table.sv
tb/sv/timer_scoreboard_pkg.sv
tb/sv/tb_top.sv
